// ===== src/dmbs_pkg.sv =====
// package for the depth map bilinear splat core: constants, types, command and register codes
package dmbs_pkg;

  localparam int DEF_MAX_WIDTH   = 256;
  localparam int DEF_MAX_HEIGHT  = 256;
  localparam int DEF_DEPTH_BITS  = 24;
  localparam int DEF_WEIGHT_BITS = 16;

  localparam int CMD_W = 2;
  localparam int POS_W = 16;
  localparam int DIN_W = 24;
  localparam int DOUT_W = 24;
  localparam int WOUT_W = 16;
  localparam int CNT_W = 3;
  localparam int DIM_W = 9;
  localparam int DIFF_W = 23;
  localparam int ADDR_W = 2;

  localparam logic [CMD_W-1:0] CMD_SPLAT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic [ADDR_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [ADDR_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [ADDR_W-1:0] REG_DIFF   = 2'd2;
  localparam logic [ADDR_W-1:0] REG_INIT   = 2'd3;

  localparam int WEIGHT_ONE = 256;

  // control handed from the top level sequencer to the divider
  typedef struct packed {
    logic start;
  } div_ctl_t;

endpackage

// ===== src/dmbs_ram.sv =====
// generic single port ram with registered read
module dmbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== src/dmbs_div.sv =====
// restoring divider, one quotient bit per cycle, truncating; caller bias rounds to nearest
module dmbs_div #(
  parameter int NW = 64,
  parameter int DW = 34
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dmbs_pkg::div_ctl_t   ctl,
  input  logic [NW-1:0]        num,
  input  logic [DW-1:0]        den,
  output logic                 done,
  output logic [NW-1:0]        quo
);
  import dmbs_pkg::*;
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] q;
  logic [DW:0]   r;
  logic [DW-1:0] dv;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   rs;

  // numerator is pre-biased by den/2 in the caller: round to nearest, ties away from zero
  assign rs = {r[DW-1:0], q[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      q  <= num;
      r  <= '0;
      dv <= den;
    end else if (busy) begin
      if (rs >= {1'b0, dv}) begin
        r <= rs - {1'b0, dv};
        q <= {q[NW-2:0], 1'b1};
      end else begin
        r <= rs;
        q <= {q[NW-2:0], 1'b0};
      end
    end
  end
  assign quo = q;
endmodule

// ===== src/depth_map_bilinear_splat_core.sv =====
// top level of the depth map bilinear splat core
//
// requests enter on in_valid/in_stall with command, x_pos, y_pos, depth_in.
// each request gives exactly one result on out_valid/out_stall carrying
// depth_value, weight_value, corners_updated and out_of_range.
// commands: splat merges a depth into the four pixels around a Q8.8 position,
// read returns one pixel, clear refills the depth store with init_depth and
// the weight store with 256, or with 0 when init_depth is negative.
// configuration (map width, map height, merge distance limit, init depth) goes
// through the apb port at byte addresses 0, 4, 8, 12; pready is always high.
// one request is in flight at a time; in_stall is high while it is worked on.
// each corner of a splat that merges is divided on a shared divider, one
// quotient bit a cycle (NW = divider width, 42 by default); one ram port.
// clear writes one entry a cycle.
// after reset a clearing pass writes init_depth (reset value) to every entry,
// while no request is taken.
// the result waits in an output register while out_stall is high; the next
// request is taken meanwhile and its result waits until that register is free.
module depth_map_bilinear_splat_core #(
  parameter int MAX_WIDTH   = dmbs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = dmbs_pkg::DEF_MAX_HEIGHT,
  parameter int DEPTH_BITS  = dmbs_pkg::DEF_DEPTH_BITS,
  parameter int WEIGHT_BITS = dmbs_pkg::DEF_WEIGHT_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dmbs_pkg::CMD_W-1:0]    command,
  input  logic [dmbs_pkg::POS_W-1:0]    x_pos,
  input  logic [dmbs_pkg::POS_W-1:0]    y_pos,
  input  logic signed [dmbs_pkg::DIN_W-1:0] depth_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [dmbs_pkg::DOUT_W-1:0] depth_value,
  output logic [dmbs_pkg::WOUT_W-1:0]   weight_value,
  output logic [dmbs_pkg::CNT_W-1:0]    corners_updated,
  output logic                          out_of_range,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import dmbs_pkg::*;

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int XW    = $clog2(MAX_WIDTH + 1);
  localparam int YW    = $clog2(MAX_HEIGHT + 1);
  // product of old depth and weight plus new term, one sign bit of headroom
  localparam int PW    = DEPTH_BITS + WEIGHT_BITS + 2;
  localparam int SW    = WEIGHT_BITS + 1;
  localparam logic [WEIGHT_BITS-1:0] WTOP = '1;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RADDR = 4'd2;
  localparam logic [3:0] S_RWAIT = 4'd3;
  localparam logic [3:0] S_RDAT  = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_WAIT  = 4'd7;
  localparam logic [3:0] S_WR    = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;
  localparam logic [3:0] S_FILL  = 4'd10;

  // configuration registers
  logic [DIM_W-1:0]         map_width, map_height;
  logic [DIFF_W-1:0]        diff_limit;
  logic signed [DIN_W-1:0]  init_depth;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= DIM_W'(256);
      map_height <= DIM_W'(256);
      diff_limit <= DIFF_W'(6144);
      init_depth <= -DIN_W'(4096);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_WIDTH:  map_width  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: map_height <= pwdata[DIM_W-1:0];
        REG_DIFF:   diff_limit <= pwdata[DIFF_W-1:0];
        REG_INIT:   init_depth <= pwdata[DIN_W-1:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = 32'(map_width);
      REG_HEIGHT: prdata = 32'(map_height);
      REG_DIFF:   prdata = 32'(diff_limit);
      REG_INIT:   prdata = 32'(unsigned'(32'(signed'(init_depth))));
      default:    prdata = '0;
    endcase
  end

  // effective map size, saturated into the supported range
  logic [XW-1:0] eff_w;
  logic [YW-1:0] eff_h;
  always_comb begin
    if (map_width < DIM_W'(2)) eff_w = XW'(2);
    else if (32'(map_width) > MAX_WIDTH) eff_w = XW'(MAX_WIDTH);
    else eff_w = XW'(map_width);
    if (map_height < DIM_W'(2)) eff_h = YW'(2);
    else if (32'(map_height) > MAX_HEIGHT) eff_h = YW'(MAX_HEIGHT);
    else eff_h = YW'(map_height);
  end

  // request registers
  logic [3:0]               state;
  logic [CMD_W-1:0]         cmd;
  logic [7:0]               colr, rowr, fx, fy;
  logic signed [DIN_W-1:0]  dnew;
  logic [1:0]               corner;
  logic [CNT_W-1:0]         count;
  logic [AW:0]              fcnt;
  logic [AW-1:0]            addr;
  logic                     oor;
  // pixel read for the request in flight, kept apart from the output register
  logic signed [DOUT_W-1:0] rd_depth;
  logic [WOUT_W-1:0]        rd_weight;

  // shared rams
  logic                      ram_we;
  logic [AW-1:0]             ram_addr;
  logic [DEPTH_BITS-1:0]     d_wdata, d_rdata;
  logic [WEIGHT_BITS-1:0]    w_wdata, w_rdata;

  dmbs_ram #(.WIDTH(DEPTH_BITS), .DEPTH(CELLS)) u_dram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(d_wdata), .rdata(d_rdata));
  dmbs_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(CELLS)) u_wram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(w_wdata), .rdata(w_rdata));

  // corner geometry and bilinear weight of the current corner
  logic [8:0]  xm, ym;
  logic [17:0] prod;
  logic [9:0]  cw;
  logic [XW+YW:0] lin;
  always_comb begin
    xm = (corner == 2'd1 || corner == 2'd2) ? {1'b0, fx} : 9'd256 - {1'b0, fx};
    ym = (corner == 2'd2 || corner == 2'd3) ? {1'b0, fy} : 9'd256 - {1'b0, fy};
    prod = xm * ym;
    cw = 10'((prod + 18'd128) >> 8);
    lin = (XW+YW+1)'(({1'b0, rowr} + ((corner[1]) ? 9'd1 : 9'd0)) * eff_w)
        + (XW+YW+1)'({1'b0, colr} + ((corner == 2'd1 || corner == 2'd2) ? 9'd1 : 9'd0));
  end

  // merge arithmetic, pipelined over the sequencer states
  logic signed [DEPTH_BITS-1:0] old_d;
  logic [WEIGHT_BITS-1:0]       old_w;
  logic [9:0]                   cwr;
  logic [SW-1:0]                sum;
  logic signed [PW-1:0]         num;
  logic                         merge;
  logic [PW-1:0]                mag;
  logic                         neg;
  div_ctl_t                     dctl;
  logic                         ddone;
  logic [PW-1:0]                quo;
  logic signed [DEPTH_BITS:0]   dext, nexts, diff;

  assign dext  = (DEPTH_BITS+1)'(dnew);
  assign nexts = {old_d[DEPTH_BITS-1], old_d};
  assign diff  = (nexts >= dext) ? nexts - dext : dext - nexts;

  // sign and magnitude of num, stable from S_DIV until the corner is written
  assign neg = num[PW-1];
  assign mag = num[PW-1] ? PW'(-num) : PW'(num);

  dmbs_div #(.NW(PW), .DW(SW)) u_div (
    .clk(clk), .rst(rst), .ctl(dctl), .num(mag + PW'(sum >> 1)), .den(sum),
    .done(ddone), .quo(quo));

  logic [PW-1:0] qs;
  assign qs = neg ? -quo : quo;

  always_comb begin
    ram_we   = 1'b0;
    ram_addr = addr;
    d_wdata  = qs[DEPTH_BITS-1:0];
    w_wdata  = (sum > SW'(WTOP)) ? WTOP : sum[WEIGHT_BITS-1:0];
    dctl.start = 1'b0;
    unique case (state)
      S_CLR, S_FILL: begin
        ram_we   = 1'b1;
        ram_addr = fcnt[AW-1:0];
        d_wdata  = DEPTH_BITS'(init_depth);
        w_wdata  = init_depth[DIN_W-1] ? '0 : WEIGHT_BITS'(WEIGHT_ONE);
      end
      S_MUL: dctl.start = 1'b0;
      S_DIV: dctl.start = merge;
      S_WR:  ram_we = merge;
      default: ;
    endcase
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      fcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_CLR, S_FILL: begin
          fcnt <= fcnt + 1'b1;
          if (fcnt == (AW+1)'(CELLS - 1)) begin
            state <= (state == S_CLR) ? S_IDLE : S_OUT;
          end
        end
        S_IDLE: if (in_valid) begin
          cmd  <= command;
          colr <= x_pos[15:8];
          rowr <= y_pos[15:8];
          fx   <= x_pos[7:0];
          fy   <= y_pos[7:0];
          dnew <= depth_in;
          corner <= 2'd0;
          count  <= '0;
          oor    <= 1'b0;
          rd_depth  <= '0;
          rd_weight <= '0;
          fcnt <= '0;
          if (command == CMD_CLEAR) state <= S_FILL;
          else if (command == CMD_SPLAT || command == CMD_READ) state <= S_RADDR;
          else state <= S_OUT;
        end
        S_RADDR: begin
          if (cmd == CMD_READ) begin
            if ({1'b0, colr} >= 9'(eff_w) || {1'b0, rowr} >= 9'(eff_h)) begin
              oor <= 1'b1;
              state <= S_OUT;
            end else begin
              addr  <= AW'(lin);
              state <= S_RWAIT;
            end
          end else if ({1'b0, colr} + 9'd1 >= 9'(eff_w) ||
                       {1'b0, rowr} + 9'd1 >= 9'(eff_h)) begin
            oor <= 1'b1;
            state <= S_OUT;
          end else begin
            addr  <= AW'(lin);
            cwr   <= cw;
            state <= S_RWAIT;
          end
        end
        S_RWAIT: state <= S_RDAT;
        S_RDAT: begin
          old_d <= d_rdata;
          old_w <= w_rdata;
          if (cmd == CMD_READ) begin
            rd_depth  <= DOUT_W'(signed'(d_rdata));
            rd_weight <= WOUT_W'(w_rdata);
            state <= S_OUT;
          end else state <= S_MUL;
        end
        S_MUL: begin
          sum   <= SW'(old_w) + SW'(cwr);
          num   <= PW'(old_d) * signed'({1'b0, old_w})
                 + PW'(dnew) * signed'({1'b0, cwr});
          merge <= (old_d[DEPTH_BITS-1] || diff < (DEPTH_BITS+1)'(diff_limit))
                   && (old_w != '0 || cwr != '0);
          state <= S_DIV;
        end
        S_DIV: state <= S_WAIT;
        S_WAIT: if (!merge || ddone) state <= S_WR;
        S_WR: begin
          if (merge) count <= count + 1'b1;
          corner <= corner + 1'b1;
          state <= (corner == 2'd3) ? S_OUT : S_RADDR;
        end
        S_OUT: if (!out_valid) begin
          depth_value     <= rd_depth;
          weight_value    <= rd_weight;
          corners_updated <= count;
          out_of_range    <= oor;
          out_valid       <= 1'b1;
          state           <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_req: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall) else $error("request not held");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(corners_updated)))
    else $error("result dropped");
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (corners_updated <= CNT_W'(4))) else $error("count too big");
  a_oor: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_of_range) |-> corners_updated == '0) else $error("oor with writes");
endmodule

// ===== dv/depth_map_bilinear_splat_core_tb.sv =====
// testbench for the depth map bilinear splat core: directed and random requests against a predictor
module depth_map_bilinear_splat_core_tb;
  import dmbs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
  localparam int WEIGHT_TOP = (1 << DEF_WEIGHT_BITS) - 1;

  // one result as the block should report it
  typedef struct {
    logic signed [DOUT_W-1:0] depth;
    logic [WOUT_W-1:0]        weight;
    logic [CNT_W-1:0]         corners;
    logic                     oor;
  } pixel_result_t;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic [CMD_W-1:0]         command;
  logic [POS_W-1:0]         x_pos;
  logic [POS_W-1:0]         y_pos;
  logic signed [DIN_W-1:0]  depth_in;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [DOUT_W-1:0] depth_value;
  logic [WOUT_W-1:0]        weight_value;
  logic [CNT_W-1:0]         corners_updated;
  logic                     out_of_range;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [3:0]               paddr;
  logic [31:0]              pwdata;
  logic [31:0]              prdata;
  logic                     pready;

  depth_map_bilinear_splat_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .x_pos(x_pos), .y_pos(y_pos), .depth_in(depth_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .depth_value(depth_value), .weight_value(weight_value),
    .corners_updated(corners_updated), .out_of_range(out_of_range),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor copy of both stores and of the registers
  longint        depth_map [CELLS];
  int unsigned   weight_map [CELLS];
  logic [DIM_W-1:0]        map_w_reg;
  logic [DIM_W-1:0]        map_h_reg;
  logic [DIFF_W-1:0]       merge_limit;
  logic signed [DIN_W-1:0] fill_depth;

  pixel_result_t pending_results[$];
  int            fail_count;
  bit            idle_on;       // random gaps and stalls enabled
  int            hold_cycles;   // long receiver hold-off, counted down below
  longint        depth_base;    // center of the depths used by well-formed splats
  int            depth_spread;

  // clock: 10 ns period
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // refill both stores the way a clear does
  task automatic refill_maps();
    int unsigned wfill;
    wfill = (fill_depth >= 0) ? WEIGHT_ONE : 0;
    for (int i = 0; i < CELLS; i++) begin
      depth_map[i] = fill_depth;
      weight_map[i] = wfill;
    end
  endtask

  function automatic int eff_width();
    return (map_w_reg < 2) ? 2 : (map_w_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(map_w_reg);
  endfunction

  function automatic int eff_height();
    return (map_h_reg < 2) ? 2 : (map_h_reg > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(map_h_reg);
  endfunction

  // work out the result of one request and update the predictor stores
  task automatic fuse_request(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] xp,
                              input logic [POS_W-1:0] yp, input logic signed [DIN_W-1:0] din,
                              output pixel_result_t res);
    int w, h, col, row, lm, rm, tm, bm, idx, cnt;
    int cw[4], cx[4], cy[4];
    longint oldd, d, diff, num, mag, q;
    longint unsigned wo, total;
    logic signed [DOUT_W-1:0] trunc;
    w = eff_width();
    h = eff_height();
    col = xp >> 8;
    row = yp >> 8;
    d = din;
    res.depth = '0;
    res.weight = '0;
    res.corners = '0;
    res.oor = 1'b0;
    if (cmd == CMD_SPLAT) begin
      if (col + 1 >= w || row + 1 >= h) begin
        res.oor = 1'b1;
      end else begin
        lm = xp[7:0];
        rm = 256 - lm;
        tm = yp[7:0];
        bm = 256 - tm;
        cw[0] = (rm * bm + 128) >> 8; cx[0] = col;     cy[0] = row;
        cw[1] = (lm * bm + 128) >> 8; cx[1] = col + 1; cy[1] = row;
        cw[2] = (lm * tm + 128) >> 8; cx[2] = col + 1; cy[2] = row + 1;
        cw[3] = (rm * tm + 128) >> 8; cx[3] = col;     cy[3] = row + 1;
        cnt = 0;
        for (int k = 0; k < 4; k++) begin
          idx = cy[k] * w + cx[k];
          oldd = depth_map[idx];
          wo = weight_map[idx];
          diff = (oldd >= d) ? oldd - d : d - oldd;
          total = wo + cw[k];
          // merge when the stored depth is invalid or close enough and the weights sum above zero
          if ((oldd < 0 || diff < longint'(merge_limit)) && total != 0) begin
            num = oldd * longint'(wo) + d * cw[k];
            mag = (num < 0) ? -num : num;
            q = (mag + longint'(total / 2)) / longint'(total);
            if (num < 0) q = -q;
            trunc = q[DOUT_W-1:0];
            depth_map[idx] = trunc;
            weight_map[idx] = 32'((total > WEIGHT_TOP) ? WEIGHT_TOP : total);
            cnt++;
          end
        end
        res.corners = CNT_W'(cnt);
      end
    end else if (cmd == CMD_READ) begin
      if (col >= w || row >= h) begin
        res.oor = 1'b1;
      end else begin
        idx = row * w + col;
        res.depth = DOUT_W'(depth_map[idx]);
        res.weight = WOUT_W'(weight_map[idx]);
      end
    end else if (cmd == CMD_CLEAR) begin
      refill_maps();
    end
  endtask

  // present one request, hold it until taken, then predict its result
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] xp,
                              input logic [POS_W-1:0] yp, input logic signed [DIN_W-1:0] din);
    pixel_result_t res;
    int gap;
    if (idle_on && $urandom_range(0, 99) < 28) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    command <= cmd;
    x_pos <= xp;
    y_pos <= yp;
    depth_in <= din;
    do @(posedge clk); while (in_stall);
    fuse_request(cmd, xp, yp, din, res);
    pending_results = {pending_results, res};
  endtask

  // let every expected result arrive, with the request line idle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // register write: setup cycle then access cycle
  task automatic write_reg(input logic [ADDR_W-1:0] regsel, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {regsel, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (regsel)
      REG_WIDTH:  map_w_reg = value[DIM_W-1:0];
      REG_HEIGHT: map_h_reg = value[DIM_W-1:0];
      REG_DIFF:   merge_limit = value[DIFF_W-1:0];
      REG_INIT:   fill_depth = value[DIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_map(input int w, input int h, input int lim, input int init);
    drain();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_DIFF, lim);
    write_reg(REG_INIT, init);
  endtask

  // one random request: mostly well-formed splats and reads inside the map
  task automatic random_request();
    int w, h, r;
    logic [POS_W-1:0] xp, yp;
    logic signed [DIN_W-1:0] din;
    w = eff_width();
    h = eff_height();
    r = $urandom_range(0, 99);
    xp = {8'($urandom_range(0, w - 2)), 8'($urandom)};
    yp = {8'($urandom_range(0, h - 2)), 8'($urandom)};
    din = DIN_W'(depth_base + $signed($urandom_range(0, 2 * depth_spread)) - depth_spread);
    if (r < 8) din = -$signed(24'($urandom_range(1, 4096)));
    if (r < 60) begin
      send_request(CMD_SPLAT, xp, yp, din);
    end else if (r < 85) begin
      send_request(CMD_READ, {8'($urandom_range(0, w - 1)), 8'($urandom)},
                   {8'($urandom_range(0, h - 1)), 8'($urandom)}, 24'($urandom));
    end else if (r < 97) begin
      send_request(($urandom_range(0, 1) != 0) ? CMD_SPLAT : CMD_READ,
                   16'($urandom), 16'($urandom), 24'($urandom));
    end else begin
      send_request(CMD_UNUSED, 16'($urandom), 16'($urandom), 24'($urandom));
    end
  endtask

  // edges of positions and depths, every command, off-map cases, clear
  task automatic test_directed();
    send_request(CMD_READ, 16'h0000, 16'h0000, 24'sd0);
    send_request(CMD_SPLAT, 16'h0000, 16'h0000, 24'sh7FFFFF);
    send_request(CMD_SPLAT, 16'h00FF, 16'h00FF, 24'sh7FFFF0);
    send_request(CMD_SPLAT, 16'h0080, 16'h0080, 24'sd100);   // far from stored, not merged
    send_request(CMD_READ, 16'h0000, 16'h0000, 24'sd0);
    send_request(CMD_READ, 16'h0100, 16'h0100, 24'sd0);
    send_request(CMD_SPLAT, 16'hFE40, 16'hFEC0, 24'sd8192);  // last in-map corner square
    send_request(CMD_SPLAT, 16'hFF00, 16'h0000, 24'sd8192);  // right column off map
    send_request(CMD_SPLAT, 16'h0000, 16'hFF00, 24'sd8192);  // lower row off map
    send_request(CMD_READ, 16'hFFFF, 16'hFFFF, 24'sd0);
    send_request(CMD_SPLAT, 16'h1234, 16'h4321, 24'sh800000);
    send_request(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 24'shFFFFFF);
    drain();
    write_reg(REG_WIDTH, 32'd8);
    write_reg(REG_HEIGHT, 32'd5);
    send_request(CMD_READ, 16'h0800, 16'h0000, 24'sd0);      // read column off map
    send_request(CMD_READ, 16'h0700, 16'h0400, 24'sd0);
    send_request(CMD_SPLAT, 16'h06FF, 16'h03FF, 24'sd5000);
    send_request(CMD_SPLAT, 16'h0700, 16'h0000, 24'sd5000);
    drain();
    write_reg(REG_INIT, 32'd12288);
    send_request(CMD_CLEAR, 16'h0000, 16'h0000, 24'sd0);
    send_request(CMD_READ, 16'h0301, 16'h0202, 24'sd0);
    send_request(CMD_SPLAT, 16'h0380, 16'h0240, 24'sd13000); // merges into a valid pixel
    send_request(CMD_READ, 16'h0300, 16'h0200, 24'sd0);
  endtask

  // receiver holds off long enough that requests back up at the input
  task automatic test_backpressure();
    hold_cycles = 600;
    for (int i = 0; i < 8; i++) random_request();
  endtask

  // random phases over several map shapes and register extremes
  task automatic test_random();
    int sizes[7][4] = '{
      '{2, 2, 8388607, 0},
      '{0, 1, 6144, -8388608},
      '{5, 3, 0, 8388607},
      '{17, 9, 6144, -4096},
      '{511, 300, 2048, -1},
      '{256, 256, 40000, 4096},
      '{40, 255, 6144, -4096}};
    for (int p = 0; p < 7; p++) begin
      set_map(sizes[p][0], sizes[p][1], sizes[p][2], sizes[p][3]);
      depth_base = $urandom_range(0, 1 << 21);
      depth_spread = (p == 0) ? 64 : $urandom_range(256, 16384);
      if (p == 1 || p == 2 || p == 5) send_request(CMD_CLEAR, 16'($urandom), 16'($urandom),
                                                   24'($urandom));
      idle_on = (p != 3);   // one phase runs back to back
      for (int i = 0; i < ((p == 0) ? 400 : 140); i++) random_request();
      idle_on = 1'b1;
    end
  endtask

  // reset, then the tests in turn
  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_SPLAT;
    x_pos = '0;
    y_pos = '0;
    depth_in = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    fail_count = 0;
    idle_on = 1'b1;
    hold_cycles = 0;
    map_w_reg = 9'd256;
    map_h_reg = 9'd256;
    merge_limit = 23'd6144;
    fill_depth = -24'sd4096;
    refill_maps();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random();
    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // receiver stalls: random, or held during the hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (hold_cycles > 0) || (idle_on && $urandom_range(0, 99) < 28);
      if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    end
  end

  // compare every accepted result with the oldest expectation
  always @(posedge clk) begin
    pixel_result_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request pending", $time);
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (depth_value !== exp_res.depth) begin
          $display("%0t: depth_value expected %0d actual %0d", $time, exp_res.depth,
                   depth_value);
          fail_count++;
        end
        if (weight_value !== exp_res.weight) begin
          $display("%0t: weight_value expected %0d actual %0d", $time, exp_res.weight,
                   weight_value);
          fail_count++;
        end
        if (corners_updated !== exp_res.corners) begin
          $display("%0t: corners_updated expected %0d actual %0d", $time, exp_res.corners,
                   corners_updated);
          fail_count++;
        end
        if (out_of_range !== exp_res.oor) begin
          $display("%0t: out_of_range expected %0d actual %0d", $time, exp_res.oor,
                   out_of_range);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #100ms;
    $display("Verification failed");
    $finish;
  end

endmodule
